>>> src/rmh_pkg.sv
// ----------------------------------------------------------------------------
// rmh_pkg: shared types and constants of the running median block
// Sizes of the two heaps, sample and result widths, and the command and
// status records that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rmh_pkg;

  localparam int unsigned Capacity   = 1024;
  localparam int unsigned SampleBits = 16;
  localparam int unsigned HeapDepth  = (Capacity + 1) / 2;
  localparam int unsigned AddrBits   = $clog2(HeapDepth);
  localparam int unsigned SizeBits   = $clog2(HeapDepth + 1);
  localparam int unsigned CountBits  = 11;
  localparam int unsigned MedBits    = SampleBits + 1;

  // Sources of the held median.
  localparam logic [1:0] MedSelX   = 2'd0;  // twice the sample
  localparam logic [1:0] MedSelLo  = 2'd1;  // twice the lower top
  localparam logic [1:0] MedSelUp  = 2'd2;  // twice the upper top
  localparam logic [1:0] MedSelSum = 2'd3;  // sum of both tops

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic signed [MedBits-1:0]    med_t;
  typedef logic [AddrBits-1:0]          addr_t;
  typedef logic [SizeBits-1:0]          size_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;       // register the incoming sample
    logic    sel_upper;  // heap that the memory operation addresses
    logic    rd_en;      // read heap at rd_addr
    addr_t   rd_addr;
    logic    wr_en;      // write wr_data to heap at wr_addr
    addr_t   wr_addr;
    logic    wr_cur;     // 1: write the carried value, 0: write the read data
    logic    cur_from_x; // carried value takes the sample
    logic    cur_from_rd;// carried value takes the read data
    logic    top_lo_x;   // lower top shadow takes the carried value
    logic    top_up_x;   // upper top shadow takes the carried value
    logic    kid_a;      // latch read data as first child
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic    x_below;    // doubled sample below held median
    logic    x_above;    // doubled sample above held median
    logic    cur_beats_lo; // carried value ranks above read data, max order
    logic    cur_beats_up; // carried value ranks above read data, min order
    logic    b_beats_a_lo; // read data (second child) above first child, max
    logic    b_beats_a_up;
    logic    a_beats_cur_lo; // first child above carried value, max
    logic    a_beats_cur_up;
    sample_t top_lo;
    sample_t top_up;
  } stat_t;

endpackage

>>> src/running_median_two_heaps.sv
// ----------------------------------------------------------------------------
// running_median_two_heaps: streaming running median of signed samples
// Each request returns twice the median of all stored samples, the stored
// count and an overflow flag once 1024 samples are held.
// ----------------------------------------------------------------------------
// One sample is processed at a time; the insert sift-up and the replace-top
// sift-down step through the heap one level per pass, paced by the single
// read port of each heap memory. Heap contents need no reset.
module running_median_two_heaps (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [15:0] s_tdata_i,  // [15:0] sample
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [31:0] m_tdata_o,  // [16:0] median_x2, [27:17] stored_count,
                                  // [28] overflow, rest zero
  output logic        m_tuser_o
);
  import rmh_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  med_t  med;
  logic  med_we, ovf;
  logic [1:0] med_sel;
  logic [CountBits-1:0] cnt;

  rmh_ctrl u_ctrl (
    .clk_i, .rst_ni, .s_tvalid_i, .s_tready_o, .m_tvalid_o, .m_tready_i,
    .ovf_o(ovf), .count_o(cnt), .stat_i(stat), .cmd_o(cmd),
    .med_we_o(med_we), .med_sel_o(med_sel)
  );

  rmh_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sample_i(s_tdata_i), .med_we_i(med_we),
    .med_sel_i(med_sel), .stat_o(stat), .median_o(med)
  );

  assign m_tdata_o = {3'b000, ovf, cnt, med};
  assign m_tuser_o = 1'b0;

endmodule

>>> src/rmh_datapath.sv
// ----------------------------------------------------------------------------
// rmh_datapath: heap memories and comparison logic
// Holds both heap arrays, the sample being placed, the carried value of a
// sift, one child register, shadow copies of both tops and the median.
// ----------------------------------------------------------------------------
module rmh_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rmh_pkg::cmd_t  cmd_i,
  input  rmh_pkg::sample_t sample_i,
  input  logic           med_we_i,
  input  logic [1:0]     med_sel_i,
  output rmh_pkg::stat_t stat_o,
  output rmh_pkg::med_t  median_o
);
  import rmh_pkg::*;

  sample_t lo_mem [HeapDepth];
  sample_t up_mem [HeapDepth];
  sample_t rd_q, x_q, cur_q, kid_q, top_lo_q, top_up_q;
  med_t    med_q;
  sample_t wr_data;

  assign wr_data = cmd_i.wr_cur ? cur_q : rd_q;

  // Heap memories with registered read data.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && !cmd_i.sel_upper) lo_mem[cmd_i.wr_addr] <= wr_data;
    if (cmd_i.wr_en &&  cmd_i.sel_upper) up_mem[cmd_i.wr_addr] <= wr_data;
    if (cmd_i.rd_en) begin
      rd_q <= cmd_i.sel_upper ? up_mem[cmd_i.rd_addr] : lo_mem[cmd_i.rd_addr];
    end
  end

  // Working registers of the sift.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) x_q <= sample_i;
    if (cmd_i.cur_from_x) cur_q <= x_q;
    else if (cmd_i.cur_from_rd) cur_q <= rd_q;
    if (cmd_i.kid_a) kid_q <= rd_q;
    if (cmd_i.top_lo_x) top_lo_q <= cur_q;
    if (cmd_i.top_up_x) top_up_q <= cur_q;
  end

  // Held median, doubled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      med_q <= '0;
    end else if (med_we_i) begin
      case (med_sel_i)
        MedSelX:  med_q <= {x_q, 1'b0};
        MedSelLo: med_q <= {top_lo_q, 1'b0};
        MedSelUp: med_q <= {top_up_q, 1'b0};
        default:  med_q <= MedBits'(top_lo_q) + MedBits'(top_up_q);
      endcase
    end
  end

  assign stat_o.x_below        = $signed({x_q, 1'b0}) < med_q;
  assign stat_o.x_above        = $signed({x_q, 1'b0}) > med_q;
  assign stat_o.cur_beats_lo   = cur_q > rd_q;
  assign stat_o.cur_beats_up   = cur_q < rd_q;
  assign stat_o.b_beats_a_lo   = rd_q > kid_q;
  assign stat_o.b_beats_a_up   = rd_q < kid_q;
  assign stat_o.a_beats_cur_lo = kid_q > cur_q;
  assign stat_o.a_beats_cur_up = kid_q < cur_q;
  assign stat_o.top_lo         = top_lo_q;
  assign stat_o.top_up         = top_up_q;
  assign median_o              = med_q;

endmodule

>>> src/rmh_ctrl.sv
// ----------------------------------------------------------------------------
// rmh_ctrl: sequencer of the running median
// Decides where a sample goes and steps the sift-up of an insert and the
// sift-down of a replace-top through the heap memories, one level per pass.
// ----------------------------------------------------------------------------
module rmh_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  output logic           s_tready_o,
  output logic           m_tvalid_o,
  input  logic           m_tready_i,
  output logic           ovf_o,
  output logic [rmh_pkg::CountBits-1:0] count_o,
  input  rmh_pkg::stat_t stat_i,
  output rmh_pkg::cmd_t  cmd_o,
  output logic           med_we_o,
  output logic [1:0]     med_sel_o
);
  import rmh_pkg::*;

  localparam logic [4:0] StIdle   = 5'd0;
  localparam logic [4:0] StDecide = 5'd1;
  localparam logic [4:0] StMvRd   = 5'd2;  // read top of losing heap
  localparam logic [4:0] StMvWait = 5'd3;
  localparam logic [4:0] StUpSet  = 5'd4;  // start push of cur
  localparam logic [4:0] StUpRd   = 5'd5;
  localparam logic [4:0] StUpWait = 5'd6;
  localparam logic [4:0] StUpCmp  = 5'd7;
  localparam logic [4:0] StDnSet  = 5'd8;
  localparam logic [4:0] StDnRdA  = 5'd9;
  localparam logic [4:0] StDnRdB  = 5'd10;
  localparam logic [4:0] StDnLatA = 5'd11;
  localparam logic [4:0] StDnCmp  = 5'd12;
  localparam logic [4:0] StDnPick = 5'd13;
  localparam logic [4:0] StMed    = 5'd14;
  localparam logic [4:0] StOut    = 5'd15;
  localparam logic [4:0] StTopLd  = 5'd16;
  localparam logic [4:0] StTopWt  = 5'd17;
  localparam logic [4:0] StTopSv  = 5'd18;
  localparam logic [4:0] StMedWr  = 5'd19; // update median from fresh tops

  logic [4:0] st_q, st_d;
  size_t lsz_q, lsz_d, usz_q, usz_d;
  addr_t i_q, i_d, p_q, p_d, best_q, best_d;
  logic  heap_q, heap_d;       // heap of the current sift, 1 = upper
  logic  dn_q, dn_d;           // replace-top pending after push
  logic  dnh_q, dnh_d;         // heap for replace-top
  logic  ovf_q, ovf_d;
  logic [1:0] msel_q, msel_d;
  logic  topsel_q, topsel_d;   // which top shadow to refresh
  logic  tops2_q, tops2_d;     // refresh other top too
  logic  aval_q, aval_d;
  logic [AddrBits:0] l_w, r_w;
  logic [SizeBits:0] hsize;
  logic  beats, b_a, a_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; lsz_q <= '0; usz_q <= '0; i_q <= '0; p_q <= '0;
      best_q <= '0; heap_q <= 1'b0; dn_q <= 1'b0; dnh_q <= 1'b0;
      ovf_q <= 1'b0; msel_q <= MedSelX; topsel_q <= 1'b0; tops2_q <= 1'b0;
      aval_q <= 1'b0;
    end else begin
      st_q <= st_d; lsz_q <= lsz_d; usz_q <= usz_d; i_q <= i_d; p_q <= p_d;
      best_q <= best_d; heap_q <= heap_d; dn_q <= dn_d; dnh_q <= dnh_d;
      ovf_q <= ovf_d; msel_q <= msel_d; topsel_q <= topsel_d;
      tops2_q <= tops2_d; aval_q <= aval_d;
    end
  end

  assign hsize = heap_q ? {1'b0, usz_q} : {1'b0, lsz_q};
  assign l_w   = {i_q, 1'b1};
  assign r_w   = l_w + 1'b1;
  assign beats = heap_q ? stat_i.cur_beats_up : stat_i.cur_beats_lo;
  assign b_a   = heap_q ? stat_i.b_beats_a_up : stat_i.b_beats_a_lo;
  assign a_c   = heap_q ? stat_i.a_beats_cur_up : stat_i.a_beats_cur_lo;

  assign s_tready_o = (st_q == StIdle);
  assign m_tvalid_o = (st_q == StOut);
  assign ovf_o      = ovf_q;
  assign count_o    = CountBits'(lsz_q) + CountBits'(usz_q);
  assign med_sel_o  = msel_q;

  // Next state and commands.
  always_comb begin
    st_d = st_q; lsz_d = lsz_q; usz_d = usz_q; i_d = i_q; p_d = p_q;
    best_d = best_q; heap_d = heap_q; dn_d = dn_q; dnh_d = dnh_q;
    ovf_d = ovf_q; msel_d = msel_q; topsel_d = topsel_q; tops2_d = tops2_q;
    aval_d = aval_q;
    cmd_o = '0;
    cmd_o.sel_upper = heap_q;
    med_we_o = 1'b0;
    case (st_q)
      StIdle: begin
        cmd_o.load = s_tvalid_i;
        if (s_tvalid_i) st_d = StDecide;
      end
      StDecide: begin
        ovf_d = 1'b0; dn_d = 1'b0; tops2_d = 1'b0;
        cmd_o.cur_from_x = 1'b1;
        if (count_o >= CountBits'(Capacity)) begin
          ovf_d = 1'b1; st_d = StOut;
        end else if (count_o == '0) begin
          heap_d = 1'b0; msel_d = MedSelX; topsel_d = 1'b0; st_d = StUpSet;
        end else if (lsz_q > usz_q) begin
          msel_d = MedSelSum; heap_d = 1'b1; topsel_d = 1'b1;
          if (stat_i.x_below) begin
            dn_d = 1'b1; dnh_d = 1'b0; tops2_d = 1'b1; st_d = StMvRd;
          end else st_d = StUpSet;
        end else if (lsz_q == usz_q) begin
          if (stat_i.x_below) begin
            heap_d = 1'b0; msel_d = MedSelLo; topsel_d = 1'b0;
          end else begin
            heap_d = 1'b1; msel_d = MedSelUp; topsel_d = 1'b1;
          end
          st_d = StUpSet;
        end else begin
          msel_d = MedSelSum; heap_d = 1'b0; topsel_d = 1'b0;
          if (stat_i.x_above) begin
            dn_d = 1'b1; dnh_d = 1'b1; tops2_d = 1'b1; st_d = StMvRd;
          end else st_d = StUpSet;
        end
      end
      // Fetch the top of the heap that gives one up; it becomes the carry.
      StMvRd: begin
        cmd_o.sel_upper = dnh_q; cmd_o.rd_en = 1'b1; cmd_o.rd_addr = '0;
        st_d = StMvWait;
      end
      StMvWait: begin
        cmd_o.cur_from_rd = 1'b1; st_d = StUpSet;
      end
      // Insert: place the carry at the end, then sift up.
      StUpSet: begin
        i_d = heap_q ? addr_t'(usz_q) : addr_t'(lsz_q);
        if (heap_q) usz_d = usz_q + 1'b1; else lsz_d = lsz_q + 1'b1;
        st_d = StUpRd;
      end
      StUpRd: begin
        if (i_q == '0) begin
          cmd_o.wr_en = 1'b1; cmd_o.wr_cur = 1'b1; cmd_o.wr_addr = i_q;
          st_d = dn_q ? StDnSet : StTopLd;
        end else begin
          p_d = (i_q - 1'b1) >> 1;
          cmd_o.rd_en = 1'b1; cmd_o.rd_addr = (i_q - 1'b1) >> 1;
          st_d = StUpWait;
        end
      end
      StUpWait: st_d = StUpCmp;
      StUpCmp: begin
        cmd_o.wr_en = 1'b1; cmd_o.wr_addr = i_q;
        if (beats) begin
          cmd_o.wr_cur = 1'b0; i_d = p_q; st_d = StUpRd;
        end else begin
          cmd_o.wr_cur = 1'b1; st_d = dn_q ? StDnSet : StTopLd;
        end
      end
      // Replace-top: carry the sample down from the root.
      StDnSet: begin
        heap_d = dnh_q; i_d = '0; cmd_o.cur_from_x = 1'b1; st_d = StDnRdA;
      end
      StDnRdA: begin
        if ({1'b0, l_w} >= hsize) begin
          cmd_o.wr_en = 1'b1; cmd_o.wr_cur = 1'b1; cmd_o.wr_addr = i_q;
          dn_d = 1'b0; st_d = StTopLd;
        end else begin
          cmd_o.rd_en = 1'b1; cmd_o.rd_addr = l_w[AddrBits-1:0];
          st_d = StDnRdB;
        end
      end
      // Left child is on the read data now; keep it while the right is read.
      StDnRdB: begin
        cmd_o.kid_a = 1'b1;
        aval_d = ({1'b0, r_w} < hsize);
        cmd_o.rd_en = ({1'b0, r_w} < hsize); cmd_o.rd_addr = r_w[AddrBits-1:0];
        st_d = StDnLatA;
      end
      StDnLatA: begin
        st_d = StDnCmp;
      end
      StDnCmp: begin
        // kid_q holds left, rd_q holds right when present.
        if (aval_q && b_a) best_d = r_w[AddrBits-1:0];
        else best_d = l_w[AddrBits-1:0];
        st_d = StDnPick;
      end
      StDnPick: begin
        if (aval_q && b_a) begin
          if (beats) begin
            cmd_o.wr_en = 1'b1; cmd_o.wr_cur = 1'b1; cmd_o.wr_addr = i_q;
            dn_d = 1'b0; st_d = StTopLd;
          end else begin
            cmd_o.wr_en = 1'b1; cmd_o.wr_cur = 1'b0; cmd_o.wr_addr = i_q;
            i_d = best_q; st_d = StDnRdA;
          end
        end else begin
          if (a_c) begin
            // Move the left child up: reload it through the read port.
            cmd_o.rd_en = 1'b1; cmd_o.rd_addr = best_q;
            i_d = i_q; st_d = StMed;
            aval_d = 1'b0;
          end else begin
            cmd_o.wr_en = 1'b1; cmd_o.wr_cur = 1'b1; cmd_o.wr_addr = i_q;
            dn_d = 1'b0; st_d = StTopLd;
          end
        end
      end
      // Left child read back; write it to the parent and go down.
      StMed: begin
        if (!aval_q) begin
          aval_d = 1'b1;
        end else begin
          cmd_o.wr_en = 1'b1; cmd_o.wr_cur = 1'b0; cmd_o.wr_addr = i_q;
          i_d = best_q; st_d = StDnRdA;
        end
      end
      // Refresh the top shadows from memory, then update the median.
      StTopLd: begin
        cmd_o.sel_upper = topsel_q; cmd_o.rd_en = 1'b1; cmd_o.rd_addr = '0;
        st_d = StTopWt;
      end
      StTopWt: begin
        cmd_o.cur_from_rd = 1'b1; st_d = StTopSv;
      end
      StTopSv: begin
        cmd_o.top_lo_x = !topsel_q; cmd_o.top_up_x = topsel_q;
        if (tops2_q) begin
          tops2_d = 1'b0; topsel_d = !topsel_q; st_d = StTopLd;
        end else begin
          st_d = StMedWr;
        end
      end
      // Both top shadows are settled here.
      StMedWr: begin
        med_we_o = 1'b1; st_d = StOut;
      end
      StOut: begin
        if (m_tready_i) st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

endmodule

>>> tb/running_median_two_heaps_tb.sv
// ----------------------------------------------------------------------------
// running_median_two_heaps_tb: self-checking testbench of the running median
// Sends signed samples with random gaps, stalls the result side at random and
// compares each result with a two-heap predictor kept in the testbench. The
// run covers extremes, duplicates, the capacity limit and the overflow flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module running_median_two_heaps_tb;
  import rmh_pkg::*;

  localparam int Depth = (Capacity + 1) / 2;

  typedef struct {
    med_t               median_x2;
    logic [CountBits-1:0] stored_count;
    logic               overflow;
  } median_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid_i;
  logic        s_tready_o;
  logic [15:0] s_tdata_i;   // [15:0] sample
  logic        m_tvalid_o;
  logic        m_tready_i;
  logic [31:0] m_tdata_o;   // [16:0] median_x2, [27:17] stored_count, [28] overflow
  logic        m_tuser_o;

  // Predictor state: max-heap of the lower half, min-heap of the upper half.
  int lower_q[Depth];
  int upper_q[Depth];
  int lower_n;
  int upper_n;
  int held_median_x2;

  median_result_t pending_medians[$];
  int  mismatches;
  int  n_sent;
  bit  rx_stall_mode;

  running_median_two_heaps u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

  // Clock, 10 ns period.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Heap access, selected by which half is meant.
  function automatic int heap_rd(bit upper, int i);
    return upper ? upper_q[i] : lower_q[i];
  endfunction

  function automatic void heap_wr(bit upper, int i, int v);
    if (upper) upper_q[i] = v;
    else lower_q[i] = v;
  endfunction

  // The lower heap keeps its largest on top, the upper heap its smallest.
  function automatic bit outranks(bit upper, int a, int b);
    return upper ? (a < b) : (a > b);
  endfunction

  function automatic void heap_insert(bit upper, int v);
    int i;
    int p;
    int t;
    i = upper ? upper_n : lower_n;
    heap_wr(upper, i, v);
    if (upper) upper_n++;
    else lower_n++;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!outranks(upper, heap_rd(upper, i), heap_rd(upper, p))) break;
      t = heap_rd(upper, i);
      heap_wr(upper, i, heap_rd(upper, p));
      heap_wr(upper, p, t);
      i = p;
    end
  endfunction

  function automatic void heap_swap_top(bit upper, int v);
    int i;
    int l;
    int best;
    int n;
    int t;
    n = upper ? upper_n : lower_n;
    i = 0;
    heap_wr(upper, 0, v);
    forever begin
      l = 2 * i + 1;
      best = i;
      if (l < n && outranks(upper, heap_rd(upper, l), heap_rd(upper, best))) best = l;
      if (l + 1 < n && outranks(upper, heap_rd(upper, l + 1), heap_rd(upper, best)))
        best = l + 1;
      if (best == i) break;
      t = heap_rd(upper, i);
      heap_wr(upper, i, heap_rd(upper, best));
      heap_wr(upper, best, t);
      i = best;
    end
  endfunction

  // Updates the heaps with one accepted sample and queues the expected result.
  function automatic void predict_median(sample_t s);
    int x;
    int n;
    median_result_t r;
    x = s;
    n = lower_n + upper_n;
    r.overflow = 1'b0;
    if (n >= Capacity) begin
      r.overflow = 1'b1;
    end else if (n == 0) begin
      heap_insert(1'b0, x);
      held_median_x2 = 2 * x;
    end else if (lower_n > upper_n) begin
      if (2 * x < held_median_x2) begin
        heap_insert(1'b1, lower_q[0]);
        heap_swap_top(1'b0, x);
      end else begin
        heap_insert(1'b1, x);
      end
      held_median_x2 = lower_q[0] + upper_q[0];
    end else if (lower_n == upper_n) begin
      if (2 * x < held_median_x2) begin
        heap_insert(1'b0, x);
        held_median_x2 = 2 * lower_q[0];
      end else begin
        heap_insert(1'b1, x);
        held_median_x2 = 2 * upper_q[0];
      end
    end else begin
      if (2 * x > held_median_x2) begin
        heap_insert(1'b0, upper_q[0]);
        heap_swap_top(1'b1, x);
      end else begin
        heap_insert(1'b0, x);
      end
      held_median_x2 = lower_q[0] + upper_q[0];
    end
    r.median_x2    = med_t'(held_median_x2);
    r.stored_count = (CountBits)'(lower_n + upper_n);
    pending_medians.push_back(r);
  endfunction

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sends one request and waits for it to be accepted; called at a falling edge.
  task automatic send_sample(input sample_t s);
    int gap;
    gap = pick_gap();
    repeat (gap) @(negedge clk_i);
    s_tvalid_i = 1'b1;
    s_tdata_i  = s;
    do @(posedge clk_i); while (!s_tready_o);
    predict_median(s);
    n_sent++;
    @(negedge clk_i);
    s_tvalid_i = 1'b0;
    s_tdata_i  = sample_t'($urandom);
  endtask

  task automatic wait_all_results();
    while (pending_medians.size() != 0) @(negedge clk_i);
  endtask

  // Random value with a bias towards duplicates, near-zero and extreme values.
  function automatic sample_t pick_sample();
    int k;
    k = $urandom_range(0, 9);
    if (k < 5) return sample_t'($urandom);
    if (k < 7) return sample_t'($urandom_range(0, 8) - 4);
    if (k < 8) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    return sample_t'($urandom_range(0, 200) + 1000);
  endfunction

  // Result side: stall at random, with stretches of always ready.
  always @(negedge clk_i) begin
    if ($urandom_range(0, 63) == 0) rx_stall_mode <= ~rx_stall_mode;
    if (!rx_stall_mode) m_tready_i <= 1'b1;
    else if ($urandom_range(0, 19) == 0) m_tready_i <= 1'b0;
    else m_tready_i <= ($urandom_range(0, 3) != 0) ? 1'b1 : m_tready_i & 1'b0;
  end

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    median_result_t e;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (pending_medians.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", m_tdata_o);
      end else begin
        e = pending_medians.pop_front();
        if (m_tdata_o[16:0] !== e.median_x2 || m_tdata_o[27:17] !== e.stored_count ||
            m_tdata_o[28] !== e.overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("median mismatch: exp med %0d cnt %0d ovf %0b, got med %0d cnt %0d ovf %0b",
                     e.median_x2, e.stored_count, e.overflow, $signed(m_tdata_o[16:0]),
                     m_tdata_o[27:17], m_tdata_o[28]);
        end
      end
    end
  end

  // Extremes, first sample, ties and alternating sides.
  task automatic test_directed();
    sample_t seq[20];
    seq = '{16'sh0000, 16'sh7fff, 16'sh8000, -16'sd1, 16'sd1, 16'sh7fff, 16'sh7fff,
            16'sh8000, 16'sh8000, 16'sd0, 16'sd0, 16'sd5, -16'sd5, 16'sh5555,
            16'shaaaa, 16'sd2, 16'sd2, -16'sd2, 16'sh7ffe, 16'sh8001};
    foreach (seq[i]) send_sample(seq[i]);
  endtask

  // Fills the heaps towards capacity, pausing once until all results are in.
  task automatic test_fill();
    int i;
    i = 0;
    while (lower_n + upper_n < Capacity) begin
      send_sample(pick_sample());
      i++;
      if (i == 300) wait_all_results();
    end
  endtask

  // Capacity reached: every further sample is dropped.
  task automatic test_overflow();
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    while (n_sent < 1600) send_sample(pick_sample());
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_tvalid_i    = 1'b0;
    s_tdata_i     = '0;
    m_tready_i    = 1'b0;
    rx_stall_mode = 1'b0;
    mismatches    = 0;
    n_sent        = 0;
    lower_n       = 0;
    upper_n       = 0;
    held_median_x2 = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_fill();
    test_overflow();
    wait_all_results();
    repeat (200) @(negedge clk_i);
    if (mismatches == 0 && pending_medians.size() == 0)
      $display("running_median_two_heaps_tb passed");
    else
      $display("running_median_two_heaps_tb failed");
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #20ms;
    $display("running_median_two_heaps_tb failed");
    $finish;
  end

endmodule

>>> files.f
src/rmh_pkg.sv
src/rmh_datapath.sv
src/rmh_ctrl.sv
src/running_median_two_heaps.sv
tb/running_median_two_heaps_tb.sv
